/* sv/pus_pkg.sv */
// Package for the percent unescape stream: character constants, held-state codes,
// the bundle type passed from the front end to the back end, and hex helpers.
// Depends on nothing.
`default_nettype none

package pus_pkg;

    localparam logic [7:0] CH_PCT  = 8'h25;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LF   = 8'h66;
    localparam logic [7:0] HEX_TEN = 8'd10;

    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_PCT   = 2'd1;
    localparam logic [1:0] HELD_DIGIT = 2'd2;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            is_end;
    } bnd_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[CH_0:CH_9]}) || (c inside {[CH_LA:CH_LF]})
            || (c inside {[CH_UA:CH_UF]});
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c <= CH_9)
        begin
            v = c - CH_0;
        end
        else if (c <= CH_UF)
        begin
            v = c - CH_UA + HEX_TEN;
        end
        else
        begin
            v = c - CH_LA + HEX_TEN;
        end
        return v[3:0];
    endfunction

endpackage

`default_nettype wire

/* sv/pus_if.sv */
// Handshake interfaces of the percent unescape stream: raw input, decoded output
// and the capacity write channel. Depends on nothing.
`default_nettype none

interface pus_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_end;
    modport source (output valid, output in_byte, output is_end, input ready);
    modport sink   (input valid, input in_byte, input is_end, output ready);
endinterface

interface pus_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        is_last;
    logic [15:0] total_len;
    logic        too_short;
    modport source (output valid, output out_byte, output byte_valid, output is_last,
                    output total_len, output too_short, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input is_last,
                    input total_len, input too_short, output ready);
endinterface

interface pus_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_capacity;
    modport source (output valid, output out_capacity, input ready);
    modport sink   (input valid, input out_capacity, output ready);
endinterface

`default_nettype wire

/* sv/pus_front.sv */
// Front end: accepts raw bytes, tracks a pending escape and turns each item into a
// bundle of up to three literal or decoded bytes. Depends on pus_pkg and pus_if.
`default_nettype none

module pus_front
    import pus_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    pus_in_if.sink    rx,
    input  wire logic q_full,
    output logic      q_push,
    output bnd_t      q_data
);

    logic [1:0] held_reg;
    logic [1:0] held_next;
    logic [7:0] digit_reg;
    logic [7:0] digit_next;
    logic       accept;

    assign rx.ready = !q_full;
    assign accept   = rx.valid && !q_full;
    assign q_push   = accept && (q_data.cnt != 2'd0);

    always_comb
    begin
        logic [1:0] n;
        logic [7:0] b;
        n          = 2'd0;
        b          = rx.in_byte;
        q_data     = '0;
        held_next  = held_reg;
        digit_next = digit_reg;
        case (held_reg)
            HELD_NONE:
            begin
                if (b == CH_PCT)
                begin
                    held_next = HELD_PCT;
                end
                else
                begin
                    q_data.bytes[n] = b;
                    n = n + 2'd1;
                end
            end
            HELD_PCT:
            begin
                if (is_hex(b))
                begin
                    held_next  = HELD_DIGIT;
                    digit_next = b;
                end
                else
                begin
                    q_data.bytes[n] = CH_PCT;
                    n = n + 2'd1;
                    if (b == CH_PCT)
                    begin
                        held_next = HELD_PCT;
                    end
                    else
                    begin
                        held_next = HELD_NONE;
                        q_data.bytes[n] = b;
                        n = n + 2'd1;
                    end
                end
            end
            HELD_DIGIT:
            begin
                if (is_hex(b))
                begin
                    held_next = HELD_NONE;
                    q_data.bytes[n] = {hex_val(digit_reg), hex_val(b)};
                    n = n + 2'd1;
                end
                else
                begin
                    q_data.bytes[n] = CH_PCT;
                    n = n + 2'd1;
                    q_data.bytes[n] = digit_reg;
                    n = n + 2'd1;
                    if (b == CH_PCT)
                    begin
                        held_next = HELD_PCT;
                    end
                    else
                    begin
                        held_next = HELD_NONE;
                        q_data.bytes[n] = b;
                        n = n + 2'd1;
                    end
                end
            end
            default:
            begin
                held_next = HELD_NONE;
            end
        endcase
        if (rx.is_end)
        begin
            if (held_next != HELD_NONE)
            begin
                q_data.bytes[n] = CH_PCT;
                n = n + 2'd1;
            end
            if (held_next == HELD_DIGIT)
            begin
                q_data.bytes[n] = digit_next;
                n = n + 2'd1;
            end
            held_next = HELD_NONE;
        end
        q_data.cnt    = n;
        q_data.is_end = rx.is_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= HELD_NONE;
        end
        else if (accept)
        begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

`default_nettype wire

/* sv/pus_queue.sv */
// Short queue of byte bundles between the front end and the back end.
// Depends on pus_pkg.
`default_nettype none

module pus_queue
    import pus_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire bnd_t push_data,
    input  wire logic pop,
    output logic      full,
    output logic      empty,
    output bnd_t      head
);

    bnd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] rd_reg;
    logic [QPTR_W:0]   fill_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (fill_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* sv/pus_back.sv */
// Back end: delivers bundle bytes one per cycle unless the receiver stalls, counts them
// against the capacity register and flags overflow. Depends on pus_pkg and pus_if.
`default_nettype none

module pus_back
    import pus_pkg::*;
#(
    parameter int unsigned LEN_WIDTH = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    pus_cfg_if.sink   cfg,
    input  wire bnd_t q_head,
    input  wire logic q_empty,
    output logic      q_pop,
    pus_out_if.source tx
);

    localparam int unsigned CW = (LEN_WIDTH > 16) ? LEN_WIDTH : 16;

    logic [15:0]          cap_reg;
    logic [LEN_WIDTH-1:0] cnt_reg;
    logic [LEN_WIDTH-1:0] cnt_inc;
    logic                 ovf_reg;
    logic                 ovf_new;
    logic [1:0]           pos_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 byte_valid_reg;
    logic                 is_last_reg;
    logic [15:0]          total_reg;
    logic                 too_short_reg;
    logic                 advance;
    logic                 load;
    logic                 last_of_bnd;
    logic                 in_cap;
    logic [CW-1:0]        cnt_ext;
    logic [15:0]          total_new;

    assign cfg.ready = 1'b1;

    assign advance     = !out_valid_reg || tx.ready;
    assign load        = advance && !q_empty;
    assign last_of_bnd = (pos_reg == (q_head.cnt - 2'd1));
    assign q_pop       = load && last_of_bnd;

    assign in_cap   = CW'(cnt_reg) < CW'(cap_reg);
    assign ovf_new  = ovf_reg || !in_cap;
    assign cnt_inc  = (cnt_reg != {LEN_WIDTH{1'b1}}) ? cnt_reg + 1'b1 : cnt_reg;
    assign cnt_ext  = CW'(cnt_inc);
    assign total_new = (cnt_ext > CW'(16'hFFFF)) ? 16'hFFFF : cnt_ext[15:0];

    assign tx.valid      = out_valid_reg;
    assign tx.out_byte   = out_byte_reg;
    assign tx.byte_valid = byte_valid_reg;
    assign tx.is_last    = is_last_reg;
    assign tx.total_len  = total_reg;
    assign tx.too_short  = too_short_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= 16'hFFFF;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            pos_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                cap_reg <= cfg.out_capacity;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
                if (last_of_bnd)
                begin
                    pos_reg <= 2'd0;
                    if (q_head.is_end)
                    begin
                        cnt_reg <= '0;
                        ovf_reg <= 1'b0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_inc;
                        ovf_reg <= ovf_new;
                    end
                end
                else
                begin
                    pos_reg <= pos_reg + 2'd1;
                    cnt_reg <= cnt_inc;
                    ovf_reg <= ovf_new;
                end
            end
            else if (tx.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg   <= in_cap ? q_head.bytes[pos_reg] : 8'd0;
            byte_valid_reg <= in_cap;
            is_last_reg    <= q_head.is_end && last_of_bnd;
            total_reg      <= total_new;
            too_short_reg  <= ovf_new;
        end
    end

endmodule

`default_nettype wire

/* sv/percent_unescape_stream.sv */
// Top level of the percent unescape stream: front end, bundle queue and back end.
// Depends on pus_pkg, pus_if, pus_front, pus_queue and pus_back.
//
// The block accepts one raw byte per cycle while its four-entry bundle queue has
// room. Each accepted item yields zero to three result items: a byte that starts or
// continues an escape gives none, a plain byte or a completed escape gives one, a
// failed escape gives the held bytes literally, and the final item of the data
// flushes anything still held. The back end delivers one result item per cycle,
// unless the receiver stalls, through its output register, so an item with several
// results holds the output side for each in turn; the queue absorbs these bursts.
// Each result item is registered there from the bundle at the head of the queue.
// Capacity writes are taken at any time and should be made while the block is idle.
`default_nettype none

module percent_unescape_stream
    import pus_pkg::*;
#(
    parameter int unsigned LEN_WIDTH = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    pus_cfg_if.sink   cfg,
    pus_in_if.sink    rx,
    pus_out_if.source tx
);

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    bnd_t q_in;
    bnd_t q_head;

    pus_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    pus_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    pus_back #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_head  (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .tx      (tx)
    );

endmodule

`default_nettype wire

/* dv/percent_unescape_stream_test.sv */
// Self-checking test of percent_unescape_stream: a directed table of expected results, then
// random escaped data under random stalls on both sides, checked by an in-bench decoder;
// every result item is compared. Depends on pus_pkg, pus_if and percent_unescape_stream.
module percent_unescape_stream_test;
    import pus_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned RANDOM_ITEMS  = 85;
    localparam int unsigned CAP_EVERY     = 30;
    localparam logic [15:0] CAP_MAX       = 16'hFFFF;
    localparam int          PREDICTED     = -1;
    localparam int          N_DIRECTED    = 26;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        is_last;
        logic [15:0] total_len;
        logic        too_short;
    } dec_res_t;

    typedef enum logic {ROW_ITEM, ROW_CAP} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [7:0]  in_byte;
        logic        is_end;
        logic [15:0] cap;
        int          n;
        dec_res_t    r0;
        dec_res_t    r1;
        dec_res_t    r2;
    } dir_row_t;

    logic clk;
    logic rst_n;

    pus_in_if  rx_if ();
    pus_out_if tx_if ();
    pus_cfg_if cfg_if ();

    percent_unescape_stream #(.LEN_WIDTH(16)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if.sink),
        .rx    (rx_if.sink),
        .tx    (tx_if.source)
    );

    // Decoder state as seen from outside the block.
    logic [7:0]  esc_buf [2];
    logic [1:0]  esc_state;
    logic [15:0] dec_count;
    logic        ovf_seen;
    logic [15:0] capacity;

    dec_res_t    step_out [$];
    dec_res_t    due_results [$];
    logic [7:0]  msg_bytes [$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left = 0;
    int fails = 0;
    int items_sent = 0;
    int msgs_sent = 0;
    int results_seen = 0;
    int cap_writes = 0;
    int unsigned cycles = 0;

    dir_row_t dir_table [N_DIRECTED] = '{
        '{ROW_ITEM, 8'h00, 1'b0, '0, 1, '{8'h00, 1'b1, 1'b0, 16'd1, 1'b0}, '0, '0},
        '{ROW_ITEM, 8'hFF, 1'b0, '0, 1, '{8'hFF, 1'b1, 1'b0, 16'd2, 1'b0}, '0, '0},
        '{ROW_ITEM, CH_PCT, 1'b0, '0, 0, '0, '0, '0},
        '{ROW_ITEM, "4", 1'b0, '0, 0, '0, '0, '0},
        '{ROW_ITEM, "1", 1'b0, '0, 1, '{8'h41, 1'b1, 1'b0, 16'd3, 1'b0}, '0, '0},
        '{ROW_ITEM, CH_PCT, 1'b0, '0, 0, '0, '0, '0},
        '{ROW_ITEM, "f", 1'b0, '0, 0, '0, '0, '0},
        '{ROW_ITEM, "F", 1'b0, '0, 1, '{8'hFF, 1'b1, 1'b0, 16'd4, 1'b0}, '0, '0},
        '{ROW_ITEM, CH_PCT, 1'b0, '0, 0, '0, '0, '0},
        '{ROW_ITEM, "g", 1'b0, '0, 2, '{CH_PCT, 1'b1, 1'b0, 16'd5, 1'b0},
          '{8'h67, 1'b1, 1'b0, 16'd6, 1'b0}, '0},
        '{ROW_ITEM, CH_PCT, 1'b0, '0, PREDICTED, '0, '0, '0},
        '{ROW_ITEM, "A", 1'b0, '0, PREDICTED, '0, '0, '0},
        '{ROW_ITEM, "z", 1'b0, '0, PREDICTED, '0, '0, '0},
        '{ROW_ITEM, CH_PCT, 1'b0, '0, 0, '0, '0, '0},
        '{ROW_ITEM, CH_PCT, 1'b0, '0, 1, '{CH_PCT, 1'b1, 1'b0, 16'd10, 1'b0}, '0, '0},
        '{ROW_ITEM, "9", 1'b0, '0, 0, '0, '0, '0},
        '{ROW_ITEM, CH_PCT, 1'b1, '0, 3, '{CH_PCT, 1'b1, 1'b0, 16'd11, 1'b0},
          '{8'h39, 1'b1, 1'b0, 16'd12, 1'b0}, '{CH_PCT, 1'b1, 1'b1, 16'd13, 1'b0}},
        '{ROW_ITEM, CH_PCT, 1'b1, '0, 1, '{CH_PCT, 1'b1, 1'b1, 16'd1, 1'b0}, '0, '0},
        '{ROW_CAP, 8'h00, 1'b0, 16'd1, 0, '0, '0, '0},
        '{ROW_ITEM, "x", 1'b0, '0, 1, '{8'h78, 1'b1, 1'b0, 16'd1, 1'b0}, '0, '0},
        '{ROW_ITEM, "y", 1'b0, '0, 1, '{8'h00, 1'b0, 1'b0, 16'd2, 1'b1}, '0, '0},
        '{ROW_ITEM, CH_PCT, 1'b0, '0, 0, '0, '0, '0},
        '{ROW_ITEM, "0", 1'b1, '0, 2, '{8'h00, 1'b0, 1'b0, 16'd3, 1'b1},
          '{8'h00, 1'b0, 1'b1, 16'd4, 1'b1}, '0},
        '{ROW_CAP, 8'h00, 1'b0, 16'd0, 0, '0, '0, '0},
        '{ROW_ITEM, "a", 1'b1, '0, 1, '{8'h00, 1'b0, 1'b1, 16'd1, 1'b1}, '0, '0},
        '{ROW_CAP, 8'h00, 1'b0, CAP_MAX, 0, '0, '0, '0}
    };

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic hex_char_ok(input logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF)
            || (c >= CH_UA && c <= CH_UF);
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if (c <= CH_9)
        begin
            return 4'(c - CH_0);
        end
        return 4'(folded - CH_LA + 8'd10);
    endfunction

    function automatic void deliver(input logic [7:0] b);
        dec_res_t r;
        logic     fits;
        fits = dec_count < capacity;
        if (!fits)
        begin
            ovf_seen = 1'b1;
        end
        if (dec_count != CAP_MAX)
        begin
            dec_count = dec_count + 16'd1;
        end
        r.out_byte   = fits ? b : 8'h00;
        r.byte_valid = fits;
        r.is_last    = 1'b0;
        r.total_len  = dec_count;
        r.too_short  = ovf_seen;
        step_out.push_back(r);
    endfunction

    function automatic void take_fresh(input logic [7:0] b);
        if (b == CH_PCT)
        begin
            esc_buf[0] = b;
            esc_state = HELD_PCT;
        end
        else
        begin
            deliver(b);
        end
    endfunction

    function automatic void decode_step(input logic [7:0] b, input logic e);
        step_out.delete();
        if (esc_state == HELD_NONE)
        begin
            take_fresh(b);
        end
        else if (esc_state == HELD_PCT)
        begin
            if (hex_char_ok(b))
            begin
                esc_buf[1] = b;
                esc_state = HELD_DIGIT;
            end
            else
            begin
                esc_state = HELD_NONE;
                deliver(esc_buf[0]);
                take_fresh(b);
            end
        end
        else
        begin
            esc_state = HELD_NONE;
            if (hex_char_ok(b))
            begin
                deliver({nibble_of(esc_buf[1]), nibble_of(b)});
            end
            else
            begin
                deliver(esc_buf[0]);
                deliver(esc_buf[1]);
                take_fresh(b);
            end
        end
        if (e)
        begin
            if (esc_state != HELD_NONE)
            begin
                deliver(esc_buf[0]);
            end
            if (esc_state == HELD_DIGIT)
            begin
                deliver(esc_buf[1]);
            end
            if (step_out.size() > 0)
            begin
                step_out[step_out.size() - 1].is_last = 1'b1;
            end
            esc_state = HELD_NONE;
            dec_count = '0;
            ovf_seen  = 1'b0;
        end
    endfunction

    function automatic logic [7:0] pick_hex();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10)
        begin
            return CH_0 + 8'(v);
        end
        if (v < 16)
        begin
            return CH_LA + 8'(v - 10);
        end
        return CH_UA + 8'(v - 16);
    endfunction

    function automatic logic [7:0] pick_non_hex();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (hex_char_ok(c));
        return c;
    endfunction

    function automatic logic [15:0] pick_capacity();
        case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return 16'($urandom_range(1, 12));
            2: return CAP_MAX;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic void build_message();
        int goal;
        int pick;
        msg_bytes.delete();
        goal = $urandom_range(1, 10);
        while (msg_bytes.size() < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                msg_bytes.push_back(CH_PCT);
                msg_bytes.push_back(pick_hex());
                msg_bytes.push_back(pick_hex());
            end
            else if (pick < 60)
            begin
                msg_bytes.push_back(CH_PCT);
                if ($urandom_range(0, 1) == 1)
                begin
                    msg_bytes.push_back(pick_hex());
                end
                msg_bytes.push_back(pick_non_hex());
            end
            else if (pick < 68)
            begin
                msg_bytes.push_back(CH_PCT);
            end
            else
            begin
                msg_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        // Some data ends inside an escape, so that the held bytes are flushed.
        if ($urandom_range(0, 99) < 15)
        begin
            msg_bytes.push_back(CH_PCT);
            if ($urandom_range(0, 1) == 1)
            begin
                msg_bytes.push_back(pick_hex());
            end
        end
    endfunction

    task automatic offer_byte(input logic [7:0] b, input logic e);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.in_byte <= b;
        rx_if.is_end  <= e;
        do
        begin
            @(posedge clk);
        end
        while (!rx_if.ready);
        items_sent++;
        if (e)
        begin
            msgs_sent++;
        end
        decode_step(b, e);
    endtask

    task automatic settle_block();
        rx_if.valid <= 1'b0;
        while (due_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] v);
        settle_block();
        cfg_if.valid        <= 1'b1;
        cfg_if.out_capacity <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        capacity = v;
        cap_writes++;
    endtask

    task automatic send_message();
        build_message();
        foreach (msg_bytes[i])
        begin
            offer_byte(msg_bytes[i], i == msg_bytes.size() - 1);
            foreach (step_out[k])
            begin
                due_results.push_back(step_out[k]);
            end
        end
    endtask

    task automatic random_phase(input int sender_idle, input int receiver_idle,
                                input logic long_hold);
        int   start;
        int   next_cap;
        logic hold_done;
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        start     = items_sent;
        next_cap  = items_sent;
        hold_done = 1'b0;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            if (items_sent >= next_cap)
            begin
                write_capacity(pick_capacity());
                next_cap = items_sent + CAP_EVERY;
            end
            // The receiver stops for a long stretch while items keep coming.
            if (long_hold && !hold_done && items_sent - start >= 40)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            send_message();
        end
    endtask

    initial
    begin
        tx_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                tx_if.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                tx_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        dec_res_t want;
        if (rst_n && tx_if.valid && tx_if.ready)
        begin
            results_seen++;
            if (due_results.size() == 0)
            begin
                $error("result item with none expected: out_byte %h total_len %0d",
                       tx_if.out_byte, tx_if.total_len);
                fails++;
            end
            else
            begin
                want = due_results.pop_front();
                if (tx_if.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %h, got %h", want.out_byte, tx_if.out_byte);
                    fails++;
                end
                if (tx_if.byte_valid !== want.byte_valid)
                begin
                    $error("byte_valid: expected %b, got %b", want.byte_valid,
                           tx_if.byte_valid);
                    fails++;
                end
                if (tx_if.is_last !== want.is_last)
                begin
                    $error("is_last: expected %b, got %b", want.is_last, tx_if.is_last);
                    fails++;
                end
                if (tx_if.total_len !== want.total_len)
                begin
                    $error("total_len: expected %0d, got %0d", want.total_len,
                           tx_if.total_len);
                    fails++;
                end
                if (tx_if.too_short !== want.too_short)
                begin
                    $error("too_short: expected %b, got %b", want.too_short, tx_if.too_short);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit with %0d result items outstanding.",
                     due_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        dir_row_t    row;
        rx_if.valid         = 1'b0;
        rx_if.in_byte       = 8'h00;
        rx_if.is_end        = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.out_capacity = 16'h0000;
        rst_n               = 1'b0;
        esc_buf[0]          = 8'h00;
        esc_buf[1]          = 8'h00;
        esc_state           = HELD_NONE;
        dec_count           = '0;
        ovf_seen            = 1'b0;
        capacity            = CAP_MAX;
        send_idle_pct       = 10;
        recv_idle_pct       = 70;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIRECTED; r++)
        begin
            row = dir_table[r];
            if (row.kind == ROW_CAP)
            begin
                write_capacity(row.cap);
            end
            else
            begin
                offer_byte(row.in_byte, row.is_end);
                if (row.n == PREDICTED)
                begin
                    foreach (step_out[k])
                    begin
                        due_results.push_back(step_out[k]);
                    end
                end
                else
                begin
                    for (int j = 0; j < row.n; j++)
                    begin
                        due_results.push_back(j == 0 ? row.r0 : (j == 1 ? row.r1 : row.r2));
                    end
                end
            end
        end

        random_phase(10, 70, 1'b1);
        random_phase(70, 10, 1'b0);
        random_phase(0, 0, 1'b0);

        settle_block();
        $display("Sent %0d input items in %0d data sets, checked %0d result items.",
                 items_sent, msgs_sent, results_seen);
        $display("Capacity was set %0d times, from zero up to the maximum.", cap_writes);
        if (fails == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
